/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define IRM_ASSERT(LABEL, PROP, MSG) \
  LABEL: assert property (@(posedge clk_i) disable iff (!rst_ni) PROP) else $error(MSG);

// Clocked assertion that also checks during reset.
`define IRM_ASSERT_ALWAYS(LABEL, PROP, MSG) \
  LABEL: assert property (@(posedge clk_i) PROP) else $error(MSG);

`endif

/* hw/rtl/irm_pkg.sv */
package irm_pkg;

  localparam int KEY_BITS    = 16;
  localparam int VALUE_BITS  = 8;
  localparam int TABLE_DEPTH = 32;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [1:0]            status_t;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic signed [KEY_BITS-1:0] range_start;
    logic signed [KEY_BITS-1:0] range_stop;
    value_t                     new_value;
    logic signed [KEY_BITS-1:0] query_key;
  } in_item_t;

  typedef struct packed {
    value_t  found_value;
    status_t status;
  } out_item_t;

  // One breakpoint; key kept in offset-binary order.
  typedef struct packed {
    key_t   key;
    value_t value;
  } entry_t;

  // Shift enables for the two breakpoint banks.
  typedef struct packed {
    logic shift_a;
    logic shift_b;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Flip the sign bit so unsigned compare follows signed order.
  function automatic key_t key_order(input logic [KEY_BITS-1:0] raw);
    key_order = {~raw[KEY_BITS-1], raw[KEY_BITS-2:0]};
  endfunction

endpackage

/* hw/rtl/irm_cell.sv */
module irm_cell (
  input  logic                clk_i,
  input  irm_pkg::chain_ctl_t ctl_i,
  input  irm_pkg::entry_t     up_a_i,
  input  irm_pkg::entry_t     up_b_i,
  output irm_pkg::entry_t     a_o,
  output irm_pkg::entry_t     b_o
);

  irm_pkg::entry_t a_q;
  irm_pkg::entry_t b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_a) begin
      a_q <= up_a_i;
    end
    if (ctl_i.shift_b) begin
      b_q <= up_b_i;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

/* hw/rtl/irm_ctrl.sv */
module irm_ctrl #(
  parameter int TABLE_DEPTH = irm_pkg::TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  irm_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output irm_pkg::out_item_t   out_item_o,
  input  logic                 cfg_valid_i,
  input  irm_pkg::value_t      cfg_wdata_i,
  input  irm_pkg::entry_t      head_a_i,
  input  irm_pkg::entry_t      head_b_i,
  output irm_pkg::chain_ctl_t  ctl_o,
  output irm_pkg::entry_t      tail_a_o,
  output irm_pkg::entry_t      tail_b_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  irm_pkg::state_e state_q, state_d;

  irm_pkg::value_t init_q, floor_q, base;
  logic            floor_ov_q, sel_q;
  logic [CW-1:0]   used_q, src_cnt_q, dst_cnt_q, m_q;
  logic            s_done_q, e_done_q, lookup_q, ovf_q;
  irm_pkg::key_t   s_q, e_q;
  irm_pkg::value_t v_q, cur_q, prev_q;
  irm_pkg::out_item_t res_q, out_q;
  logic            out_valid_q;

  irm_pkg::key_t   s_in, e_in, q_in;
  logic            acc, is_lookup, empty;

  irm_pkg::entry_t head, cand;
  irm_pkg::value_t cur_d;
  logic            live, pop, cand_v, fin, keep, full, push;
  logic            s_done_d, e_done_d;
  logic            scanning, scan_end, load_out, commit;

  assign base      = floor_ov_q ? floor_q : init_q;
  assign s_in      = irm_pkg::key_order(in_item_i.range_start);
  assign e_in      = irm_pkg::key_order(in_item_i.range_stop);
  assign q_in      = irm_pkg::key_order(in_item_i.query_key);
  assign is_lookup = in_item_i.cmd == irm_pkg::CMD_LOOKUP;
  assign empty     = !is_lookup && (s_in >= e_in);

  // Stream step: one candidate breakpoint per cycle from the source head or an insert.
  always_comb begin
    head     = sel_q ? head_b_i : head_a_i;
    live     = src_cnt_q < used_q;
    pop      = 1'b0;
    cand_v   = 1'b0;
    cand     = head;
    cur_d    = cur_q;
    s_done_d = s_done_q;
    e_done_d = e_done_q;
    fin      = 1'b0;
    if (live && head.key < s_q) begin
      pop    = 1'b1;
      cand_v = 1'b1;
      cur_d  = head.value;
    end else if (!s_done_q) begin
      s_done_d = 1'b1;
      if (s_q != '0) begin
        cand_v = 1'b1;
        cand   = '{key: s_q, value: v_q};
      end
    end else if (live && head.key <= e_q) begin
      pop   = 1'b1;
      cur_d = head.value;
    end else if (!e_done_q) begin
      e_done_d = 1'b1;
      cand_v   = 1'b1;
      cand     = '{key: e_q, value: cur_q};
    end else if (live) begin
      pop    = 1'b1;
      cand_v = 1'b1;
    end else begin
      fin = 1'b1;
      pop = src_cnt_q != DEPTH_C;
    end
    full = dst_cnt_q == DEPTH_C;
    keep = cand_v && !lookup_q && (cand.value != prev_q);
    push = !full && (keep || (fin && !lookup_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      irm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = empty ? irm_pkg::ST_DONE : irm_pkg::ST_SCAN;
        end
      end
      irm_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = irm_pkg::ST_DONE;
        end
      end
      irm_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = irm_pkg::ST_IDLE;
        end
      end
      default: state_d = irm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    acc      = 1'b0;
    scanning = 1'b0;
    load_out = 1'b0;
    case (state_q)
      irm_pkg::ST_IDLE: acc      = in_valid_i;
      irm_pkg::ST_SCAN: scanning = 1'b1;
      irm_pkg::ST_DONE: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
    scan_end = scanning && fin && (src_cnt_q == DEPTH_C) && (lookup_q || full);
    commit   = scan_end && !lookup_q && !ovf_q;
  end

  assign in_stall_o = state_q != irm_pkg::ST_IDLE;

  always_comb begin
    ctl_o.shift_a = scanning && (sel_q ? push : pop);
    ctl_o.shift_b = scanning && (sel_q ? pop : push);
    tail_a_o      = sel_q ? cand : head;
    tail_b_o      = sel_q ? head : cand;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irm_pkg::ST_IDLE;
      init_q      <= '0;
      floor_q     <= '0;
      floor_ov_q  <= 1'b0;
      sel_q       <= 1'b0;
      used_q      <= '0;
      src_cnt_q   <= '0;
      dst_cnt_q   <= '0;
      m_q         <= '0;
      s_done_q    <= 1'b0;
      e_done_q    <= 1'b0;
      lookup_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        init_q <= cfg_wdata_i;
      end
      if (acc) begin
        lookup_q  <= is_lookup;
        s_done_q  <= is_lookup;
        e_done_q  <= is_lookup;
        src_cnt_q <= '0;
        dst_cnt_q <= '0;
        m_q       <= '0;
        ovf_q     <= 1'b0;
      end else if (scanning) begin
        s_done_q <= s_done_d;
        e_done_q <= e_done_d;
        if (pop) begin
          src_cnt_q <= src_cnt_q + CW'(1);
        end
        if (push) begin
          dst_cnt_q <= dst_cnt_q + CW'(1);
        end
        if (keep && !full) begin
          m_q <= m_q + CW'(1);
        end
        if (keep && full) begin
          ovf_q <= 1'b1;
        end
      end
      if (commit) begin
        sel_q  <= ~sel_q;
        used_q <= m_q;
        if (s_q == '0) begin
          floor_q    <= v_q;
          floor_ov_q <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s_q    <= is_lookup ? '0 : s_in;
      e_q    <= is_lookup ? q_in : e_in;
      v_q    <= in_item_i.new_value;
      cur_q  <= base;
      prev_q <= (!is_lookup && s_in == '0) ? in_item_i.new_value : base;
      res_q  <= '{found_value: '0, status: irm_pkg::STATUS_EMPTY};
    end else if (scanning) begin
      cur_q <= cur_d;
      if (keep) begin
        prev_q <= cand.value;
      end
      if (scan_end) begin
        res_q.found_value <= lookup_q ? cur_q : '0;
        res_q.status      <= (!lookup_q && ovf_q) ? irm_pkg::STATUS_FULL
                                                  : irm_pkg::STATUS_DONE;
      end
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hw/rtl/interval_range_map.sv */
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_stall_o  | in_item_i  (irm_pkg::in_item_t)
// out      | output    | out_valid_o / out_stall_i| out_item_o (irm_pkg::out_item_t)
// cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_wdata_i (initial value)
//
// A lookup rotates the breakpoints once through cell 0 of the source chain. An
// assign does the same, and the rebuilt bank is padded until TABLE_DEPTH entries
// have shifted in, so a merge that shrinks a full table still waits for the padding.
// An empty interval skips the scan. Reset clears the table count, base value and
// handshake state; breakpoint cells hold garbage until written.
// One item is in flight; a finished result waits in the output register while
// the next item is already taken, and a stalled result holds the next one back.
`include "assert_macros.svh"

module interval_range_map #(
  parameter int TABLE_DEPTH = irm_pkg::TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  irm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output irm_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  irm_pkg::value_t    cfg_wdata_i
);

  // Two banks of breakpoint cells. One holds the live table and rotates
  // through cell 0 during a scan; the other takes the rebuilt table at its
  // tail. A successful assign swaps their roles.
  irm_pkg::chain_ctl_t ctl;
  irm_pkg::entry_t     tail_a, tail_b;
  irm_pkg::entry_t     a_w [TABLE_DEPTH];
  irm_pkg::entry_t     b_w [TABLE_DEPTH];

  // The register write is always taken.
  assign cfg_ready_o = 1'b1;

  irm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_a_i    (a_w[0]),
    .head_b_i    (b_w[0]),
    .ctl_o       (ctl),
    .tail_a_o    (tail_a),
    .tail_b_o    (tail_b)
  );

  // Each cell loads from its upper neighbor; the top cell loads the tail.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_top
      irm_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .up_a_i (tail_a),
        .up_b_i (tail_b),
        .a_o    (a_w[i]),
        .b_o    (b_w[i])
      );
    end else begin : g_mid
      irm_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .up_a_i (a_w[i+1]),
        .up_b_i (b_w[i+1]),
        .a_o    (a_w[i]),
        .b_o    (b_w[i])
      );
    end
  end

  // A transfer in always leaves the idle state, so the input side must stall next.
  `IRM_ASSERT(a_busy_after_transfer, in_valid_i && !in_stall_o |=> in_stall_o, "input not stalled after transfer")
  // Results with a status other than done carry a zero value.
  `IRM_ASSERT(a_assign_zero, out_valid_o && out_item_o.status != irm_pkg::STATUS_DONE |-> out_item_o.found_value == '0, "nonzero value with refusal status")
  // Status code three is never produced.
  `IRM_ASSERT(a_status_known, out_valid_o |-> out_item_o.status != 2'd3, "unknown status code")

endmodule

/* tb/sv/irm_checker.sv */
`timescale 1ns / 100ps

module irm_checker
  import irm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  value_t    cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int SCRATCH = TABLE_DEPTH + 2;

  key_t        brk_key [TABLE_DEPTH];
  value_t      brk_val [TABLE_DEPTH];
  int unsigned brk_count;
  value_t      init_val;
  value_t      floor_val;
  bit          floor_set;
  out_item_t   expected_q[$];

  function automatic key_t to_order(input logic [KEY_BITS-1:0] raw);
    return {~raw[KEY_BITS-1], raw[KEY_BITS-2:0]};
  endfunction

  function automatic value_t base_val();
    return floor_set ? floor_val : init_val;
  endfunction

  function automatic value_t value_at(input key_t k);
    value_t v;
    v = base_val();
    for (int i = 0; i < brk_count; i++)
      if (brk_key[i] <= k) v = brk_val[i];
    return v;
  endfunction

  // Rebuild the breakpoint list around [s,e), then merge equal neighbors.
  function automatic status_t assign_range(input key_t s, input key_t e, input value_t v);
    key_t        sk [SCRATCH];
    value_t      sv [SCRATCH];
    value_t      end_val;
    value_t      prev;
    int unsigned cnt;
    int unsigned merged;
    end_val = value_at(e);
    prev    = (s == '0) ? v : base_val();
    cnt     = 0;
    merged  = 0;
    for (int i = 0; i < brk_count; i++)
      if (brk_key[i] < s) begin
        sk[cnt] = brk_key[i]; sv[cnt] = brk_val[i]; cnt++;
      end
    if (s != '0) begin
      sk[cnt] = s; sv[cnt] = v; cnt++;
    end
    sk[cnt] = e; sv[cnt] = end_val; cnt++;
    for (int i = 0; i < brk_count; i++)
      if (brk_key[i] > e && cnt < SCRATCH) begin
        sk[cnt] = brk_key[i]; sv[cnt] = brk_val[i]; cnt++;
      end
    for (int i = 0; i < cnt; i++)
      if (sv[i] != prev) begin
        sk[merged] = sk[i]; sv[merged] = sv[i]; merged++;
        prev = sv[i];
      end
    if (merged > TABLE_DEPTH) return STATUS_FULL;
    for (int i = 0; i < merged; i++) begin
      brk_key[i] = sk[i];
      brk_val[i] = sv[i];
    end
    brk_count = merged;
    if (s == '0) begin
      floor_val = v;
      floor_set = 1'b1;
    end
    return STATUS_DONE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    key_t      s;
    key_t      e;
    if (!rst_ni) begin
      brk_count    = 0;
      init_val     = '0;
      floor_val    = '0;
      floor_set    = 1'b0;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) init_val = cfg_wdata_i;

      // Compare the result transfer against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        got = out_item_i;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result found_value=%0d status=%0d",
                   $time, got.found_value, got.status);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %0d actual %0d",
                     $time, want.found_value, got.found_value);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        want = '0;
        if (in_item_i.cmd == CMD_LOOKUP) begin
          want.found_value = value_at(to_order(in_item_i.query_key));
        end else begin
          s = to_order(in_item_i.range_start);
          e = to_order(in_item_i.range_stop);
          want.status = (s >= e) ? STATUS_EMPTY : assign_range(s, e, in_item_i.new_value);
        end
        expected_q.push_back(want);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

/* tb/sv/interval_range_map_tb.sv */
`timescale 1ns / 100ps

module interval_range_map_tb;

  // Settle time, chosen to outlast the longest item.
  localparam int SETTLE     = 2 * irm_pkg::TABLE_DEPTH + 8;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int RAND_ITEMS = 470;
  localparam int IN_W       = $bits(irm_pkg::in_item_t);

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  irm_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  irm_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  irm_pkg::value_t    cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 cycles;

  interval_range_map DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_wdata_i (cfg_wdata)
  );

  irm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stall, redrawn every cycle on the falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < rx_stall_pct);

  // Hold the item until the block takes it; valid stays high into the next send.
  task automatic send_item(input irm_pkg::in_item_t it);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Write the initial value; only called while the block is idle.
  task automatic write_initial(input irm_pkg::value_t v);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic irm_pkg::in_item_t make_item(input logic cmd, input int lo, input int hi,
                                                  input int val, input int key);
    irm_pkg::in_item_t it;
    it = IN_W'({$urandom, $urandom});
    it.cmd = cmd;
    if (cmd == irm_pkg::CMD_ASSIGN) begin
      it.range_start = irm_pkg::key_t'(lo);
      it.range_stop  = irm_pkg::key_t'(hi);
      it.new_value   = irm_pkg::value_t'(val);
    end else begin
      it.query_key = irm_pkg::key_t'(key);
    end
    return it;
  endfunction

  // Keys crowd a narrow window so ranges overlap, merge and fill the table.
  function automatic int pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 60) return int'($urandom_range(400)) - 200;
    if (r < 70) return $urandom_range(1) ? -32768 : 32767;
    if (r < 78) return $urandom_range(1) ? -32768 + int'($urandom_range(3))
                                         : 32767 - int'($urandom_range(3));
    return int'($signed(16'($urandom)));
  endfunction

  function automatic irm_pkg::in_item_t rand_item();
    irm_pkg::in_item_t it;
    int                a;
    int                b;
    int                t;
    it = IN_W'({$urandom, $urandom});
    if ($urandom_range(99) < 40) begin
      it.cmd       = irm_pkg::CMD_LOOKUP;
      it.query_key = irm_pkg::key_t'(pick_key());
    end else begin
      it.cmd = irm_pkg::CMD_ASSIGN;
      a = pick_key();
      b = pick_key();
      // Mostly well-ordered ranges; the rest stay empty or reversed.
      if ($urandom_range(99) < 85 && a > b) begin
        t = a; a = b; b = t;
      end
      it.range_start = irm_pkg::key_t'(a);
      it.range_stop  = irm_pkg::key_t'(b);
      if ($urandom_range(99) < 70) it.new_value = irm_pkg::value_t'($urandom_range(3));
    end
    return it;
  endfunction

  task automatic run_random(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Once, let the block run dry before carrying on.
      if (tx_pct == 18 && i == RAND_ITEMS / 2) drain();
      send_item(rand_item());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_wdata    = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    write_initial(8'd255);

    // Directed: extremes, empty intervals, base segment, largest key, full table.
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, -32768));
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, 32767));
    send_item(make_item(irm_pkg::CMD_ASSIGN, 5, 5, 9, 0));
    send_item(make_item(irm_pkg::CMD_ASSIGN, 32767, -32768, 9, 0));
    send_item(make_item(irm_pkg::CMD_ASSIGN, -32768, -100, 0, 0));
    send_item(make_item(irm_pkg::CMD_ASSIGN, 1000, 32767, 200, 0));
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, 32767));
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, 32766));
    // Each disjoint unit range adds two breakpoints; the last ones overflow.
    for (int i = 0; i < 17; i++)
      send_item(make_item(irm_pkg::CMD_ASSIGN, 2 * i, 2 * i + 1, 10 + i, 0));
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, -32768));
    send_item(make_item(irm_pkg::CMD_LOOKUP, 0, 0, 0, 4));

    write_initial(8'd0);
    run_random(18, 52);
    write_initial(irm_pkg::value_t'($urandom_range(1, 254)));
    run_random(52, 18);
    write_initial(8'd255);
    run_random(0, 0);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/irm_pkg.sv
hw/rtl/irm_cell.sv
hw/rtl/irm_ctrl.sv
hw/rtl/interval_range_map.sv
tb/sv/irm_checker.sv
tb/sv/interval_range_map_tb.sv
